// ----- rtl/utf8_sequence_sanitizer_top_defines.svh -----
// Assertion macros shared by the sanitizer.
// Each macro samples on the rising edge of clk and is disabled while rst_n is low.
`ifndef UTF8_SEQUENCE_SANITIZER_TOP_DEFINES_SVH
`define UTF8_SEQUENCE_SANITIZER_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define U8S_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sanitizer check failed");

// The consequent must hold in the cycle after the antecedent.
`define U8S_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sanitizer check failed");

`endif

// ----- rtl/utf8s_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package utf8s_pkg;

    // Masks and codes for the leading bits of a byte.
    localparam logic [7:0] ASCII_MASK  = 8'h80;
    localparam logic [7:0] LEAD2_MASK  = 8'hE0;
    localparam logic [7:0] LEAD2_CODE  = 8'hC0;
    localparam logic [7:0] LEAD3_MASK  = 8'hF0;
    localparam logic [7:0] LEAD3_CODE  = 8'hE0;
    localparam logic [7:0] LEAD4_MASK  = 8'hF8;
    localparam logic [7:0] LEAD4_CODE  = 8'hF0;
    localparam logic [7:0] FOLLOW_MASK = 8'hC0;
    localparam logic [7:0] FOLLOW_CODE = 8'h80;

    // Sequence lengths; zero means the byte cannot lead a sequence.
    localparam logic [2:0] SEQ_LEN_NONE = 3'd0;
    localparam logic [2:0] SEQ_LEN_ONE  = 3'd1;
    localparam logic [2:0] SEQ_LEN_TWO  = 3'd2;
    localparam logic [2:0] SEQ_LEN_THREE = 3'd3;
    localparam logic [2:0] SEQ_LEN_FOUR = 3'd4;

    // One incoming request.
    typedef struct packed {
        logic [7:0] in_byte;
        logic       text_last;
    } in_item_t;

    // One outgoing request.
    typedef struct packed {
        logic [7:0] out_byte;
        logic       has_byte;
        logic       run_last;
        logic       text_end;
    } out_item_t;

    // All results caused by one input byte, as queued between front and back.
    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [1:0]      last_idx;
        logic            has_byte;
        logic            text_end;
    } burst_t;

    // Queue occupancy flags.
    typedef struct packed {
        logic full;
        logic empty;
    } fifo_status_t;

    // Front-end status, exported for checking.
    typedef struct packed {
        logic idle;
    } front_status_t;

    // Sequence length announced by a lead byte.
    function automatic logic [2:0] lead_length(input logic [7:0] b);
        logic [2:0] len;
        begin
            len = SEQ_LEN_NONE;
            if ((b & ASCII_MASK) == 8'h00)
                len = SEQ_LEN_ONE;
            else if ((b & LEAD2_MASK) == LEAD2_CODE)
                len = SEQ_LEN_TWO;
            else if ((b & LEAD3_MASK) == LEAD3_CODE)
                len = SEQ_LEN_THREE;
            else if ((b & LEAD4_MASK) == LEAD4_CODE)
                len = SEQ_LEN_FOUR;
            return len;
        end
    endfunction

endpackage

`default_nettype wire

// ----- rtl/utf8s_front.sv -----
`timescale 1ns / 1ps
`default_nettype none

module utf8s_front
    import utf8s_pkg::*;
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          acc,
    input  wire in_item_t      item,
    output logic               push,
    output burst_t             burst,
    output front_status_t      status
);

    logic [2:0] exp_len_reg, exp_len_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       ok_reg, ok_next;
    logic [7:0] pend_reg [3];

    logic [2:0] len;
    logic       follow_ok;
    logic       ok_upd;
    logic       pend_we;
    logic [1:0] pend_idx;
    logic [2:0] n_res;
    logic       marker;

    // Classify the byte and work out the state update and the results it causes.
    always_comb
    begin
        len          = lead_length(item.in_byte);
        follow_ok    = (item.in_byte & FOLLOW_MASK) == FOLLOW_CODE;
        ok_upd       = ok_reg & follow_ok;
        exp_len_next = exp_len_reg;
        cnt_next     = cnt_reg;
        ok_next      = ok_reg;
        pend_we      = 1'b0;
        pend_idx     = cnt_reg;
        n_res        = 3'd0;
        marker       = 1'b0;

        if (exp_len_reg == SEQ_LEN_NONE)
        begin
            if (len == SEQ_LEN_ONE)
            begin
                n_res = 3'd1;
            end
            else if (len != SEQ_LEN_NONE)
            begin
                pend_we      = 1'b1;
                pend_idx     = 2'd0;
                exp_len_next = len;
                cnt_next     = 2'd1;
                ok_next      = 1'b1;
            end
        end
        else
        begin
            if (({1'b0, cnt_reg} + 3'd1) >= exp_len_reg)
            begin
                // Last byte of the span: release it whole, or drop it whole.
                if (ok_upd)
                    n_res = {1'b0, cnt_reg} + 3'd1;
                exp_len_next = SEQ_LEN_NONE;
                cnt_next     = 2'd0;
                ok_next      = 1'b1;
            end
            else
            begin
                pend_we  = 1'b1;
                cnt_next = cnt_reg + 2'd1;
                ok_next  = ok_upd;
            end
        end

        // End of text abandons any open sequence.
        if (item.text_last)
        begin
            exp_len_next = SEQ_LEN_NONE;
            cnt_next     = 2'd0;
            ok_next      = 1'b1;
            if (n_res == 3'd0)
            begin
                marker = 1'b1;
                n_res  = 3'd1;
            end
        end
    end

    // Assemble the burst: held bytes first, then the current byte.
    always_comb
    begin
        burst.bytes[0] = (cnt_reg == 2'd0) ? item.in_byte : pend_reg[0];
        burst.bytes[1] = (cnt_reg == 2'd1) ? item.in_byte : pend_reg[1];
        burst.bytes[2] = (cnt_reg == 2'd2) ? item.in_byte : pend_reg[2];
        burst.bytes[3] = item.in_byte;
        if (marker)
            burst.bytes[0] = 8'h00;
        burst.last_idx = 2'(n_res - 3'd1);
        burst.has_byte = !marker;
        burst.text_end = item.text_last;
    end

    assign push        = acc && (n_res != 3'd0);
    assign status.idle = (exp_len_reg == SEQ_LEN_NONE);

    // Sequence tracking state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exp_len_reg <= SEQ_LEN_NONE;
            cnt_reg     <= 2'd0;
            ok_reg      <= 1'b1;
        end
        else if (acc)
        begin
            exp_len_reg <= exp_len_next;
            cnt_reg     <= cnt_next;
            ok_reg      <= ok_next;
        end
    end

    // Held bytes of the open sequence; read only once written.
    always_ff @(posedge clk)
    begin
        if (acc && pend_we)
            pend_reg[pend_idx] <= item.in_byte;
    end

endmodule

`default_nettype wire

// ----- rtl/utf8s_fifo.sv -----
`timescale 1ns / 1ps
`default_nettype none

module utf8s_fifo
    import utf8s_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   push,
    input  wire burst_t push_data,
    input  wire logic   pop,
    output burst_t      head,
    output fifo_status_t status
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    burst_t          mem_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0]   count_reg;

    assign status.full  = (count_reg == CW'(DEPTH));
    assign status.empty = (count_reg == '0);
    assign head         = mem_reg[rd_ptr_reg];

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

endmodule

`default_nettype wire

// ----- rtl/utf8s_back.sv -----
`timescale 1ns / 1ps
`default_nettype none

module utf8s_back
    import utf8s_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire burst_t       head,
    input  wire fifo_status_t fstat,
    output logic              pop,
    output logic              valid,
    input  wire logic         stall,
    output out_item_t         item
);

    logic [1:0] idx_reg, idx_next;
    logic       acc;

    // Present one byte of the head burst per request.
    always_comb
    begin
        valid         = !fstat.empty;
        item.out_byte = head.bytes[idx_reg];
        item.has_byte = head.has_byte;
        item.run_last = (idx_reg == head.last_idx);
        item.text_end = item.run_last && head.text_end;
        acc           = valid && !stall;
        pop           = acc && item.run_last;
        idx_next      = idx_reg;
        if (acc)
            idx_next = item.run_last ? 2'd0 : idx_reg + 2'd1;
    end

    // Position within the head burst.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            idx_reg <= 2'd0;
        else
            idx_reg <= idx_next;
    end

endmodule

`default_nettype wire

// ----- rtl/utf8_sequence_sanitizer_top.sv -----
// UTF-8 sanitizer: takes one text byte per cycle and passes on only complete, well-formed
// sequences of one to four bytes; stray bytes, broken spans and spans cut off by the end of
// the text are dropped, and a text whose final byte releases nothing closes with a bare end
// marker (has_byte low). A byte is taken in every cycle while the internal queue of DEPTH
// bursts has room, and its results can appear on the output in the next cycle. Results leave
// at one per cycle while result_stall is low; the queue absorbs the bursts of completed
// sequences, and text_stall rises only once it is full.
`timescale 1ns / 1ps
`default_nettype none
`include "utf8_sequence_sanitizer_top_defines.svh"

module utf8_sequence_sanitizer_top
    import utf8s_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      text_valid,
    output logic           text_stall,
    input  wire in_item_t  text_data,
    output logic           result_valid,
    input  wire logic      result_stall,
    output out_item_t      result_data
);

    logic          in_acc;
    logic          push;
    logic          pop;
    burst_t        burst;
    burst_t        head;
    fifo_status_t  fstat;
    front_status_t front_stat;

    assign text_stall = fstat.full;
    assign in_acc     = text_valid && !text_stall;

    // Classification and sequence collection.
    utf8s_front u_front
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .acc    (in_acc),
        .item   (text_data),
        .push   (push),
        .burst  (burst),
        .status (front_stat)
    );

    // Queue of released bursts.
    utf8s_fifo #(
        .DEPTH (DEPTH)
    ) u_fifo
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (burst),
        .pop       (pop),
        .head      (head),
        .status    (fstat)
    );

    // Serialisation onto the result channel.
    utf8s_back u_back
    (
        .clk   (clk),
        .rst_n (rst_n),
        .head  (head),
        .fstat (fstat),
        .pop   (pop),
        .valid (result_valid),
        .stall (result_stall),
        .item  (result_data)
    );

    // A burst, once started, continues without a gap.
    `U8S_ASSERT_NEXT(a_burst_unbroken, result_valid && !result_stall && !result_data.run_last, result_valid)
    // A bare end marker always closes both the byte and the text.
    `U8S_ASSERT_SAME(a_marker_closes, result_valid && !result_data.has_byte, result_data.run_last && result_data.text_end)
    // The final byte of a text always leaves the front idle.
    `U8S_ASSERT_NEXT(a_idle_after_end, in_acc && text_data.text_last, front_stat.idle)
    // Nothing is written into a full queue.
    `U8S_ASSERT_SAME(a_no_overflow, push, !fstat.full)

endmodule

`default_nettype wire

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
    import utf8s_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_AFTER_ITEMS = 200;
    localparam int HOLD_CYCLES = 80;
    localparam int RANDOM_ITEMS = 460;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      text_valid = 1'b0;
    logic      text_stall;
    in_item_t  text_data = '0;
    logic      result_valid;
    logic      result_stall = 1'b0;
    out_item_t result_data;

    // Text bytes still to be offered, and sanitised bytes still awaited.
    in_item_t  raw_text_q[$];
    out_item_t sanitized_q[$];

    // Shadow of the sanitiser's sequence state.
    logic [7:0] held_bytes[3];
    logic [2:0] seq_len;
    int         held_cnt;
    logic       span_ok;

    int  error_count = 0;
    int  cycle_count = 0;
    int  items_taken = 0;
    int  queued_items = 0;
    logic text_taken = 1'b0;

    // Sender burst state and receiver stall state.
    int   burst_left = 0;
    int   gap_left = 0;
    int   rx_mode = 0;
    int   rx_mode_left = 0;
    logic rx_toggle = 1'b0;
    logic rx_hold = 1'b0;
    int   hold_left = 0;
    logic hold_done = 1'b0;

    utf8_sequence_sanitizer_top uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .text_valid   (text_valid),
        .text_stall   (text_stall),
        .text_data    (text_data),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_data  (result_data)
    );

    always #2 clk = ~clk;

    task automatic report_mismatch(input string msg);
        begin
            $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
            error_count++;
        end
    endtask

    function automatic void push_item(input logic [7:0] b, input logic last_flag);
        in_item_t item;
        begin
            item.in_byte = b;
            item.text_last = last_flag;
            raw_text_q.push_back(item);
            queued_items++;
        end
    endfunction

    // A lead byte with random payload bits for a sequence of the given length.
    function automatic logic [7:0] lead_byte(input int len);
        logic [7:0] r;
        begin
            r = 8'($urandom);
            case (len)
                1: lead_byte = {1'b0, r[6:0]};
                2: lead_byte = {3'b110, r[4:0]};
                3: lead_byte = {4'b1110, r[3:0]};
                default: lead_byte = {5'b11110, r[2:0]};
            endcase
        end
    endfunction

    function automatic logic [7:0] follow_byte();
        logic [7:0] r;
        begin
            r = 8'($urandom);
            follow_byte = {2'b10, r[5:0]};
        end
    endfunction

    function automatic void return_idle();
        begin
            seq_len = SEQ_LEN_NONE;
            held_cnt = 0;
            span_ok = 1'b1;
        end
    endfunction

    // Works out the bytes that one text byte releases and queues them.
    function automatic void sanitize_byte(input in_item_t item);
        out_item_t res[4];
        int        n;
        int        i;
        logic [7:0] b;
        logic [2:0] len;
        begin
            n = 0;
            b = item.in_byte;
            if (seq_len == SEQ_LEN_NONE) begin
                len = SEQ_LEN_NONE;
                if ((b & ASCII_MASK) == 8'h00)
                    len = SEQ_LEN_ONE;
                else if ((b & LEAD2_MASK) == LEAD2_CODE)
                    len = SEQ_LEN_TWO;
                else if ((b & LEAD3_MASK) == LEAD3_CODE)
                    len = SEQ_LEN_THREE;
                else if ((b & LEAD4_MASK) == LEAD4_CODE)
                    len = SEQ_LEN_FOUR;
                if (len == SEQ_LEN_ONE) begin
                    res[n] = '{out_byte: b, has_byte: 1'b1, run_last: 1'b0, text_end: 1'b0};
                    n++;
                end
                else if (len != SEQ_LEN_NONE) begin
                    held_bytes[0] = b;
                    seq_len = len;
                    held_cnt = 1;
                    span_ok = 1'b1;
                end
            end
            else begin
                if ((b & FOLLOW_MASK) != FOLLOW_CODE)
                    span_ok = 1'b0;
                if (held_cnt + 1 >= int'(seq_len)) begin
                    // The span is complete: release it whole or drop it whole.
                    if (span_ok) begin
                        for (i = 0; i < held_cnt; i++) begin
                            res[n] = '{out_byte: held_bytes[i], has_byte: 1'b1,
                                       run_last: 1'b0, text_end: 1'b0};
                            n++;
                        end
                        res[n] = '{out_byte: b, has_byte: 1'b1, run_last: 1'b0, text_end: 1'b0};
                        n++;
                    end
                    return_idle();
                end
                else begin
                    held_bytes[held_cnt] = b;
                    held_cnt++;
                end
            end

            // The end of the text drops any open span and always yields something.
            if (item.text_last) begin
                return_idle();
                if (n == 0) begin
                    res[n] = '{out_byte: 8'h00, has_byte: 1'b0, run_last: 1'b0, text_end: 1'b0};
                    n++;
                end
            end

            if (n > 0) begin
                res[n-1].run_last = 1'b1;
                res[n-1].text_end = item.text_last;
            end
            for (i = 0; i < n; i++)
                sanitized_q.push_back(res[i]);
        end
    endfunction

    // One text of random sequences, mostly well formed, with noise and broken spans.
    function automatic void add_random_text();
        logic [7:0] txt[$];
        int nseq;
        int kind;
        int len;
        int k;
        int nfollow;
        in_item_t item;
        begin
            nseq = $urandom_range(1, 10);
            repeat (nseq) begin
                kind = $urandom_range(0, 9);
                len = $urandom_range(1, 4);
                if (kind == 0) begin
                    txt.push_back(8'($urandom));
                end
                else begin
                    txt.push_back(lead_byte(len));
                    for (k = 1; k < len; k++) begin
                        if (kind == 1 && k == len - 1)
                            txt.push_back(8'($urandom));
                        else
                            txt.push_back(follow_byte());
                    end
                end
            end
            // Now and then the text stops part way through a sequence.
            if ($urandom_range(0, 6) == 0) begin
                len = $urandom_range(2, 4);
                txt.push_back(lead_byte(len));
                nfollow = $urandom_range(0, len - 2);
                for (k = 0; k < nfollow; k++)
                    txt.push_back(follow_byte());
            end
            for (k = 0; k < txt.size(); k++)
                push_item(txt[k], k == txt.size() - 1);
        end
    endfunction

    task automatic wait_drained();
        begin
            while (raw_text_q.size() != 0 || text_valid || sanitized_q.size() != 0)
                @(negedge clk);
        end
    endtask

    // Stimulus sequence and end of run.
    initial begin
        return_idle();
        held_bytes[0] = 8'h00;
        held_bytes[1] = 8'h00;
        held_bytes[2] = 8'h00;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Extremes of single bytes, then one well-formed sequence of each length.
        push_item(8'h00, 1'b0);
        push_item(8'h7F, 1'b0);
        push_item(8'hC2, 1'b0);
        push_item(8'hA9, 1'b0);
        push_item(8'hE2, 1'b0);
        push_item(8'h82, 1'b0);
        push_item(8'hAC, 1'b0);
        push_item(8'hF0, 1'b0);
        push_item(8'h9F, 1'b0);
        push_item(8'h98, 1'b0);
        push_item(8'h80, 1'b0);
        // Stray bytes while idle: a lone follower and a byte that can never lead.
        push_item(8'h80, 1'b0);
        push_item(8'hFF, 1'b0);
        // A bad follower drops the span, itself included.
        push_item(8'hC3, 1'b0);
        push_item(8'h41, 1'b0);
        // A span cut off by the end of the text leaves only a bare end marker.
        push_item(8'hE2, 1'b0);
        push_item(8'h82, 1'b1);
        // A final byte that gives no data.
        push_item(8'hF8, 1'b1);
        // Single-byte text, then a four-byte sequence closing the text.
        push_item(8'h41, 1'b1);
        push_item(8'hF4, 1'b0);
        push_item(8'h8F, 1'b0);
        push_item(8'hBF, 1'b0);
        push_item(8'hBF, 1'b1);

        // The sender stays quiet until the block has emptied.
        wait_drained();

        queued_items = 0;
        while (queued_items < RANDOM_ITEMS)
            add_random_text();

        wait_drained();
        repeat (16) @(negedge clk);
        if (sanitized_q.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", sanitized_q.size()));
        if (error_count == 0)
            $display("[utf8_sequence_sanitizer_top] OK");
        else
            $display("[utf8_sequence_sanitizer_top] ERROR");
        $finish;
    end

    // Sampling of both handshakes at the rising edge.
    always @(posedge clk) begin
        out_item_t want;
        text_taken <= text_valid && !text_stall;
        if (rst_n && text_valid && !text_stall) begin
            sanitize_byte(text_data);
            items_taken++;
        end
        if (rst_n && result_valid && !result_stall) begin
            if (sanitized_q.size() == 0) begin
                report_mismatch($sformatf("unexpected request byte %02h has %0b",
                                          result_data.out_byte, result_data.has_byte));
            end
            else begin
                want = sanitized_q.pop_front();
                if (result_data.out_byte !== want.out_byte)
                    report_mismatch($sformatf("out_byte %02h, want %02h",
                                              result_data.out_byte, want.out_byte));
                if (result_data.has_byte !== want.has_byte)
                    report_mismatch($sformatf("has_byte %0b, want %0b",
                                              result_data.has_byte, want.has_byte));
                if (result_data.run_last !== want.run_last)
                    report_mismatch($sformatf("run_last %0b, want %0b",
                                              result_data.run_last, want.run_last));
                if (result_data.text_end !== want.text_end)
                    report_mismatch($sformatf("text_end %0b, want %0b",
                                              result_data.text_end, want.text_end));
            end
        end
    end

    // Driver: offers text bytes in bursts, holding each until it is taken.
    always @(negedge clk) begin
        if (rst_n && (!text_valid || text_taken)) begin
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                text_valid <= 1'b0;
            end
            else if (raw_text_q.size() != 0) begin
                text_data <= raw_text_q.pop_front();
                text_valid <= 1'b1;
                if (burst_left <= 1) begin
                    // Long bursts now and then give stretches with no gaps at all.
                    burst_left <= ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                              : $urandom_range(1, 8);
                    gap_left <= $urandom_range(0, 5);
                end
                else begin
                    burst_left <= burst_left - 1;
                end
            end
            else begin
                text_valid <= 1'b0;
            end
        end
    end

    // A single long hold-off on the result side, so that the queue fills.
    always @(negedge clk) begin
        if (rst_n) begin
            if (!hold_done && items_taken >= HOLD_AFTER_ITEMS) begin
                hold_done <= 1'b1;
                hold_left <= HOLD_CYCLES;
                rx_hold <= 1'b1;
            end
            else if (hold_left > 1) begin
                hold_left <= hold_left - 1;
            end
            else begin
                hold_left <= 0;
                rx_hold <= 1'b0;
            end
        end
    end

    // Receiver stall pattern, switching between a few densities.
    always @(negedge clk) begin
        if (rst_n) begin
            if (rx_mode_left == 0) begin
                rx_mode <= $urandom_range(0, 3);
                rx_mode_left <= $urandom_range(30, 120);
            end
            else begin
                rx_mode_left <= rx_mode_left - 1;
            end
            rx_toggle <= ~rx_toggle;
            case (rx_mode)
                0: result_stall <= rx_hold;
                1: result_stall <= rx_hold || ($urandom_range(0, 3) == 0);
                2: result_stall <= rx_hold || ($urandom_range(0, 3) != 0);
                default: result_stall <= rx_hold || rx_toggle;
            endcase
        end
    end

    // Watchdog on the whole run.
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[utf8_sequence_sanitizer_top] ERROR");
            $finish;
        end
    end

endmodule
